@@ src/first_fit_heap_allocator_macros.svh @@
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define FFHA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffha: same-cycle check failed");
`define FFHA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffha: next-cycle check failed");
`else
`define FFHA_ASSERT_IMP(lbl, ante, cons)
`define FFHA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ src/ffha_pkg.sv @@
// Types, codes and constants of the first-fit heap allocator.
package ffha_pkg;
	localparam int HEAP_WORDS_DEF = 65536;
	localparam int NW = 18;

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_RESIZE  = 2'd2;
	localparam logic [1:0] CMD_INVALID = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_NULL    = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] payload_addr;
		logic [18:0] size_bytes;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] result_addr;
		logic        moved;
		logic [15:0] copy_from;
		logic [15:0] copy_words;
		logic [16:0] used_words;
	} rsp_t;
endpackage

@@ src/ffha_req_if.sv @@
// Request channel of the first-fit heap allocator.
interface ffha_req_if;
	logic          valid;
	logic          ready;
	ffha_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/ffha_rsp_if.sv @@
// Response channel of the first-fit heap allocator.
interface ffha_rsp_if;
	logic          valid;
	logic          ready;
	ffha_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/first_fit_heap_allocator.sv @@
// Handles one request at a time; each walk reads headers one at a time through the header memory
// read port, so cost grows with the number of blocks walked (locate, merge, first-fit), on top of
// setup, walk ends and header writes.
// A finished response waits in an output register while the next request is taken.
// Reset: words in use is 1 and word 0 reads as one free block over the whole heap; no sweep.
module first_fit_heap_allocator #(
	parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	ffha_req_if.sink    req,
	ffha_rsp_if.source  rsp
);
	import ffha_pkg::*;

	localparam int AW = $clog2(HEAP_WORDS);
	localparam int PW = AW + 1;
	localparam int HW = AW + 1;
	localparam int CW = ((PW > NW) ? PW : NW) + 1;
	localparam logic [CW-1:0] C_HEAP = CW'(HEAP_WORDS);
	localparam logic [HW-1:0] HDR0_RST = {AW'(HEAP_WORDS - 1), 1'b0};

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_LOC_RD = 4'd1;
	localparam logic [3:0] S_LOC_EV = 4'd2;
	localparam logic [3:0] S_MG_RD  = 4'd3;
	localparam logic [3:0] S_MG_EV  = 4'd4;
	localparam logic [3:0] S_GR_WR2 = 4'd5;
	localparam logic [3:0] S_AL_RD  = 4'd6;
	localparam logic [3:0] S_AL_EV  = 4'd7;
	localparam logic [3:0] S_AL_WR2 = 4'd8;
	localparam logic [3:0] S_AL_FIN = 4'd9;
	localparam logic [3:0] S_RESP   = 4'd10;

	logic [HW-1:0] mem [HEAP_WORDS];
	logic [HW-1:0] rdata_s1;
	logic          rd_en, wr_en;
	logic [AW-1:0] wr_addr;
	logic [HW-1:0] wr_data;

	logic [3:0]    state_q, state_d;
	logic [PW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] target_q, target_d;
	logic [AW-1:0] hp_q, hp_d;
	logic [AW-1:0] old_q, old_d;
	logic [NW-1:0] n_q, n_d;
	logic [CW-1:0] rq_q, rq_d;
	logic [AW-1:0] sum_q, sum_d;
	logic [AW-1:0] k_q, k_d;
	logic [AW-1:0] grant_q, grant_d;
	logic [PW-1:0] pay_q, pay_d;
	logic [PW-1:0] wiu_q, wiu_d;
	logic          moving_q, moving_d;
	logic          grow_q, grow_d;
	logic          free_q, free_d;
	logic [15:0]   addr_q, addr_d;
	logic [1:0]    rst_q, rst_d;
	logic [15:0]   raddr_q, raddr_d;
	logic          rmv_q, rmv_d;
	logic [15:0]   rcf_q, rcf_d;
	logic [15:0]   rcw_q, rcw_d;
	logic          w0_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	logic          rsp_load;

	logic [HW-1:0] hdr;
	logic [AW-1:0] hsz;
	logic          hused;
	logic [PW-1:0] nxt;

	assign hdr   = (ptr_q == '0 && !w0_q) ? HDR0_RST : rdata_s1;
	assign hsz   = hdr[HW-1:1];
	assign hused = hdr[0];
	assign nxt   = ptr_q + PW'(1) + PW'(hsz);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		logic [19:0]   rnd;
		logic [NW-1:0] nw;
		logic          mg_fin;
		logic [CW-1:0] base, avail, rqa;
		state_d = state_q;
		ptr_d = ptr_q; target_d = target_q; hp_d = hp_q; old_d = old_q; n_d = n_q;
		rq_d = rq_q; sum_d = sum_q; k_d = k_q; grant_d = grant_q; pay_d = pay_q;
		wiu_d = wiu_q; moving_d = moving_q; grow_d = grow_q; free_d = free_q;
		addr_d = addr_q; rst_d = rst_q; raddr_d = raddr_q; rmv_d = rmv_q;
		rcf_d = rcf_q; rcw_d = rcw_q;
		rd_en = 1'b0; wr_en = 1'b0; wr_addr = '0; wr_data = '0;
		rnd = {1'b0, req.data.size_bytes} + 20'd7;
		nw = {rnd[19:3], 1'b0};
		mg_fin = 1'b0;
		base = CW'(wiu_q) - CW'(old_q) - CW'(k_q);
		avail = (CW'(wiu_q) < C_HEAP) ? C_HEAP - CW'(wiu_q) : '0;
		rqa = (CW'(n_q) <= avail) ? CW'(n_q) : avail;
		rqa = (rqa + CW'(1)) & ~CW'(1);
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					n_d = nw; addr_d = req.data.payload_addr; ptr_d = '0;
					moving_d = 1'b0; free_d = (req.data.cmd == CMD_FREE);
					rst_d = ST_NULL; raddr_d = '0; rmv_d = 1'b0; rcf_d = '0; rcw_d = '0;
					state_d = S_RESP;
					if (req.data.cmd == CMD_ALLOC ||
					    (req.data.cmd == CMD_RESIZE && req.data.payload_addr == '0)) begin
						if (nw != '0) begin
							rq_d = CW'(nw);
							state_d = S_AL_RD;
						end
					end else if (req.data.cmd == CMD_FREE || req.data.cmd == CMD_RESIZE) begin
						if (req.data.payload_addr != '0 &&
						    32'(req.data.payload_addr) <= 32'(HEAP_WORDS - 1)) begin
							target_d = AW'(32'(req.data.payload_addr) - 32'd1);
							state_d = S_LOC_RD;
						end
					end
				end
			end
			S_LOC_RD: begin
				if (CW'(ptr_q) >= C_HEAP) state_d = S_RESP;
				else begin
					rd_en = 1'b1;
					state_d = S_LOC_EV;
				end
			end
			S_LOC_EV: begin
				if (ptr_q == PW'(target_q)) begin
					state_d = S_RESP;
					if (hused) begin
						hp_d = AW'(ptr_q); old_d = hsz; sum_d = hsz; k_d = '0; ptr_d = nxt;
						if (free_q || n_q == '0) begin
							if (free_q) rst_d = ST_OK;
							grow_d = 1'b0;
							state_d = S_MG_RD;
						end else if (CW'(hsz) >= CW'(n_q)) begin
							rst_d = ST_OK; raddr_d = addr_q;
						end else begin
							grow_d = 1'b1;
							state_d = S_MG_RD;
						end
					end
				end else if (ptr_q > PW'(target_q)) begin
					state_d = S_RESP;
				end else begin
					ptr_d = nxt;
					state_d = S_LOC_RD;
				end
			end
			S_MG_RD: begin
				if (CW'(ptr_q) >= C_HEAP) mg_fin = 1'b1;
				else begin
					rd_en = 1'b1;
					state_d = S_MG_EV;
				end
			end
			S_MG_EV: begin
				if (!hused) begin
					sum_d = sum_q + AW'(1) + hsz; k_d = k_q + AW'(1); ptr_d = nxt;
					state_d = S_MG_RD;
				end else mg_fin = 1'b1;
			end
			S_GR_WR2: begin
				wr_en = 1'b1; wr_addr = hp_q; wr_data = {AW'(n_q), 1'b1};
				state_d = S_RESP;
			end
			S_AL_RD: begin
				if (CW'(ptr_q) >= C_HEAP) begin
					rst_d = ST_NOSPACE;
					state_d = S_RESP;
				end else begin
					rd_en = 1'b1;
					state_d = S_AL_EV;
				end
			end
			S_AL_EV: begin
				if (!hused && CW'(hsz) >= rq_q) begin
					pay_d = ptr_q + PW'(1);
					wr_en = 1'b1;
					if (CW'(hsz) > rq_q) begin
						wr_addr = AW'(CW'(ptr_q) + CW'(1) + rq_q);
						wr_data = {AW'(CW'(hsz) - rq_q - CW'(1)), 1'b0};
						wiu_d = PW'(CW'(wiu_q) + rq_q + CW'(1));
						grant_d = AW'(rq_q);
						state_d = S_AL_WR2;
					end else begin
						wr_addr = AW'(ptr_q);
						wr_data = {hsz, 1'b1};
						wiu_d = wiu_q + PW'(hsz);
						grant_d = hsz;
						state_d = S_AL_FIN;
					end
				end else begin
					ptr_d = nxt;
					state_d = S_AL_RD;
				end
			end
			S_AL_WR2: begin
				wr_en = 1'b1; wr_addr = AW'(pay_q - PW'(1)); wr_data = {grant_q, 1'b1};
				state_d = S_AL_FIN;
			end
			S_AL_FIN: begin
				rst_d = ST_OK; raddr_d = 16'(pay_q);
				state_d = S_RESP;
				if (moving_q) begin
					rmv_d = 1'b1; rcf_d = addr_q;
					rcw_d = 16'((old_q < grant_q) ? old_q : grant_q);
					sum_d = old_q; k_d = '0; grow_d = 1'b0;
					ptr_d = PW'(hp_q) + PW'(1) + PW'(old_q);
					state_d = S_MG_RD;
				end
			end
			S_RESP: begin
				if (rsp_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (mg_fin) begin
			state_d = S_RESP;
			if (!grow_q) begin
				wr_en = 1'b1; wr_addr = hp_q; wr_data = {sum_q, 1'b0};
				wiu_d = PW'(base);
			end else if (CW'(sum_q) >= CW'(n_q)) begin
				rst_d = ST_OK; raddr_d = addr_q;
				wr_en = 1'b1;
				if (CW'(sum_q) > CW'(n_q)) begin
					wr_addr = AW'(CW'(hp_q) + CW'(1) + CW'(n_q));
					wr_data = {AW'(CW'(sum_q) - CW'(n_q) - CW'(1)), 1'b0};
					wiu_d = PW'(base + CW'(n_q) + CW'(1));
					state_d = S_GR_WR2;
				end else begin
					wr_addr = hp_q;
					wr_data = {sum_q, 1'b1};
					wiu_d = PW'(base + CW'(sum_q));
				end
			end else if (rqa == '0) begin
				rst_d = ST_NOSPACE;
			end else begin
				rq_d = rqa; moving_d = 1'b1; ptr_d = '0;
				state_d = S_AL_RD;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_s1 <= mem[AW'(ptr_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wiu_q <= PW'(1);
			w0_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wiu_q <= wiu_d;
			if (wr_en && wr_addr == '0) w0_q <= 1'b1;
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d; target_q <= target_d; hp_q <= hp_d; old_q <= old_d; n_q <= n_d;
		rq_q <= rq_d; sum_q <= sum_d; k_q <= k_d; grant_q <= grant_d; pay_q <= pay_d;
		moving_q <= moving_d; grow_q <= grow_d; free_q <= free_d; addr_q <= addr_d;
		rst_q <= rst_d; raddr_q <= raddr_d; rmv_q <= rmv_d; rcf_q <= rcf_d; rcw_q <= rcw_d;
		if (rsp_load) begin
			rsp_q.status      <= rst_q;
			rsp_q.result_addr <= raddr_q;
			rsp_q.moved       <= rmv_q;
			rsp_q.copy_from   <= rcf_q;
			rsp_q.copy_words  <= rcw_q;
			rsp_q.used_words  <= 17'(wiu_q);
		end
	end

`include "first_fit_heap_allocator_macros.svh"
	`FFHA_ASSERT_IMP(a_no_write_idle, state_q == S_IDLE, !wr_en)
	`FFHA_ASSERT_IMP(a_no_rw_clash, wr_en, !rd_en)
	`FFHA_ASSERT_IMP(a_wiu_bound, 1'b1, CW'(wiu_q) <= C_HEAP)
	`FFHA_ASSERT_NXT(a_leave_idle, req.valid && req.ready, state_q != S_IDLE)
	`FFHA_ASSERT_NXT(a_rsp_shown, rsp_load, rsp_valid_q)
endmodule

@@ tb/tb_first_fit_heap_allocator.sv @@
// Self-checking testbench for the first-fit heap allocator, with a scoreboard-based predictor.
module tb_first_fit_heap_allocator;
	import ffha_pkg::*;

	localparam int HW = HEAP_WORDS_DEF;
	localparam int unsigned IN_USE = 1;

	class heap_scoreboard;
		int unsigned hdr [HW];
		int unsigned in_use;
		rsp_t expected_q [$];
		rsp_t last;
		int errors;
		int checked;
		int grants;
		int moves;
		int nospace;
		int nulls;

		function new();
			for (int i = 0; i < HW; i++)
				hdr[i] = 0;
			hdr[0] = (HW - 1) << 1;
			in_use = 1;
		endfunction

		function int unsigned bsize(int unsigned p);
			return hdr[p] >> 1;
		endfunction

		function bit bused(int unsigned p);
			return (hdr[p] & IN_USE) != 0;
		endfunction

		function int unsigned bnext(int unsigned p);
			return p + 1 + bsize(p);
		endfunction

		function bit find_header(int unsigned addr, output int unsigned hp);
			int unsigned p;
			p = 0;
			hp = 0;
			if (addr == 0 || addr > HW - 1)
				return 0;
			while (p < HW) begin
				if (p == addr - 1) begin
					hp = p;
					return 1;
				end
				if (p > addr - 1)
					return 0;
				p = bnext(p);
			end
			return 0;
		endfunction

		function bit first_fit(int unsigned n, output int unsigned pay,
				output int unsigned granted);
			int unsigned p, sz, q;
			p = 0;
			pay = 0;
			granted = 0;
			while (p < HW) begin
				sz = bsize(p);
				if (!bused(p) && sz >= n) begin
					q = p + 1 + n;
					if (sz - n >= 1 && q < HW) begin
						hdr[q] = (sz - n - 1) << 1;
						hdr[p] = (n << 1) | IN_USE;
						in_use += n + 1;
						granted = n;
					end else begin
						hdr[p] |= IN_USE;
						in_use += sz;
						granted = sz;
					end
					pay = p + 1;
					return 1;
				end
				p = bnext(p);
			end
			return 0;
		endfunction

		function void release_block(int unsigned p);
			int unsigned sz, q;
			sz = bsize(p);
			in_use -= sz;
			q = bnext(p);
			while (q < HW && !bused(q)) begin
				sz += 1 + bsize(q);
				in_use -= 1;
				q = bnext(q);
			end
			hdr[p] = sz << 1;
		endfunction

		// Payload addresses of in-use (want_used=1) or free blocks.
		function void collect(bit want_used, ref int unsigned found [$]);
			int unsigned p;
			p = 0;
			found.delete();
			while (p < HW) begin
				if (bused(p) == want_used)
					found.push_back(p + 1);
				p = bnext(p);
			end
		endfunction

		function void note_request(req_t r);
			int unsigned addr, n, p, pay, granted, old, merged, k, q, rr, avail, want;
			rsp_t e;
			addr = 32'(r.payload_addr);
			n = ((int'(r.size_bytes) + 7) & ~7) >> 2;
			e = '0;
			e.status = ST_NULL;
			if (r.cmd == CMD_ALLOC || (r.cmd == CMD_RESIZE && addr == 0)) begin
				if (n == 0)
					e.status = ST_NULL;
				else if (first_fit(n, pay, granted)) begin
					e.status = ST_OK;
					e.result_addr = 16'(pay);
				end else
					e.status = ST_NOSPACE;
			end else if (r.cmd == CMD_FREE) begin
				if (find_header(addr, p) && bused(p)) begin
					release_block(p);
					e.status = ST_OK;
				end
			end else if (r.cmd == CMD_RESIZE) begin
				if (find_header(addr, p) && bused(p)) begin
					old = bsize(p);
					if (n == 0) begin
						release_block(p);
						e.status = ST_NULL;
					end else if (old >= n) begin
						e.status = ST_OK;
						e.result_addr = 16'(addr);
					end else begin
						merged = old;
						k = 0;
						q = bnext(p);
						while (q < HW && !bused(q)) begin
							merged += 1 + bsize(q);
							k++;
							q = bnext(q);
						end
						if (merged >= n) begin
							rr = p + 1 + n;
							if (merged - n >= 1 && rr < HW) begin
								hdr[rr] = (merged - n - 1) << 1;
								hdr[p] = (n << 1) | IN_USE;
								in_use = in_use - old - k + n + 1;
							end else begin
								hdr[p] = (merged << 1) | IN_USE;
								in_use = in_use - old - k + merged;
							end
							e.status = ST_OK;
							e.result_addr = 16'(addr);
						end else begin
							avail = (in_use < HW) ? HW - in_use : 0;
							want = (n <= avail) ? n : avail;
							want = (want + 1) & ~32'd1;
							if (want != 0 && first_fit(want, pay, granted)) begin
								e.copy_words = 16'((old < granted) ? old : granted);
								release_block(p);
								e.status = ST_OK;
								e.result_addr = 16'(pay);
								e.moved = 1'b1;
								e.copy_from = 16'(addr);
								moves++;
							end else
								e.status = ST_NOSPACE;
						end
					end
				end
			end
			e.used_words = 17'(in_use);
			if (e.status == ST_OK)
				grants++;
			else if (e.status == ST_NOSPACE)
				nospace++;
			else
				nulls++;
			last = e;
			expected_q.push_back(e);
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_response(rsp_t got);
			rsp_t e;
			checked++;
			if (expected_q.size() == 0) begin
				report("response with no request outstanding");
				return;
			end
			e = expected_q.pop_front();
			if (got.status !== e.status)
				report($sformatf("status %0d, expected %0d", got.status, e.status));
			if (got.result_addr !== e.result_addr)
				report($sformatf("result_addr %0d, expected %0d", got.result_addr,
					e.result_addr));
			if (got.moved !== e.moved)
				report($sformatf("moved %0d, expected %0d", got.moved, e.moved));
			if (got.copy_from !== e.copy_from)
				report($sformatf("copy_from %0d, expected %0d", got.copy_from, e.copy_from));
			if (got.copy_words !== e.copy_words)
				report($sformatf("copy_words %0d, expected %0d", got.copy_words,
					e.copy_words));
			if (got.used_words !== e.used_words)
				report($sformatf("used_words %0d, expected %0d", got.used_words,
					e.used_words));
		endtask
	endclass

	logic clk;
	logic arst_n;
	ffha_req_if req ();
	ffha_rsp_if rsp ();

	heap_scoreboard sb;
	int send_gap_pct;
	int recv_stall_pct;
	int hold_cycles;

	first_fit_heap_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#500_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Receiver: stall at random, or hold off for a counted stretch.
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				rsp.ready <= 1'b0;
			end else
				rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk)
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_response(rsp.data);

	task send_request(logic [1:0] cmd, logic [15:0] addr, logic [18:0] bytes);
		req_t r;
		r.cmd = cmd;
		r.payload_addr = addr;
		r.size_bytes = bytes;
		@(negedge clk);
		req.valid <= 1'b1;
		req.data <= r;
		do
			@(posedge clk);
		while (!req.ready);
		sb.note_request(r);
	endtask

	task idle_sender();
		while ($urandom_range(99) < send_gap_pct) begin
			@(negedge clk);
			req.valid <= 1'b0;
		end
	endtask

	function logic [18:0] pick_bytes();
		int roll;
		roll = $urandom_range(99);
		if (roll < 3)
			return 0;
		if (roll < 8)
			return 19'($urandom_range(262144));
		if (roll < 20)
			return 19'($urandom_range(4096));
		return 19'($urandom_range(1, 512));
	endfunction

	function logic [15:0] pick_addr(bit want_used);
		int unsigned found [$];
		int roll;
		roll = $urandom_range(99);
		if (roll < 12)
			return 16'($urandom_range(65535));
		sb.collect(want_used, found);
		if (found.size() == 0)
			return 16'($urandom_range(65535));
		if (roll < 16)
			return 16'(found[$urandom_range(found.size() - 1)] + 1);
		return 16'(found[$urandom_range(found.size() - 1)]);
	endfunction

	task random_request();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			send_request(CMD_ALLOC, 16'($urandom_range(65535)), pick_bytes());
		else if (roll < 66)
			send_request(CMD_FREE, pick_addr($urandom_range(9) != 0), pick_bytes());
		else if (roll < 92)
			send_request(CMD_RESIZE, pick_addr($urandom_range(9) != 0), pick_bytes());
		else if (roll < 96)
			send_request(CMD_RESIZE, 16'd0, pick_bytes());
		else
			send_request(CMD_INVALID, 16'($urandom_range(65535)), pick_bytes());
	endtask

	initial begin
		logic [15:0] a1, a2, a3, big;
		sb = new();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_request(CMD_ALLOC, 16'd0, 19'd0);
		send_request(CMD_ALLOC, 16'd0, 19'd1);
		a1 = sb.last.result_addr;
		send_request(CMD_ALLOC, 16'd0, 19'd8);
		a2 = sb.last.result_addr;
		send_request(CMD_ALLOC, 16'd0, 19'd16);
		a3 = sb.last.result_addr;
		send_request(CMD_FREE, 16'd0, 19'd0);
		send_request(CMD_FREE, a2 + 16'd1, 19'd0);
		send_request(CMD_FREE, a2, 19'd0);
		send_request(CMD_FREE, a2, 19'd0);
		send_request(CMD_RESIZE, a1, 19'd4);
		send_request(CMD_RESIZE, a1, 19'd16);
		send_request(CMD_RESIZE, a1, 19'd400);
		a1 = sb.last.result_addr;
		send_request(CMD_RESIZE, 16'd0, 19'd24);
		send_request(CMD_RESIZE, a3, 19'd0);
		send_request(CMD_INVALID, 16'hffff, 19'h7ffff);
		send_request(CMD_ALLOC, 16'd0, 19'd262144);
		send_request(CMD_ALLOC, 16'd0, 19'd240000);
		big = sb.last.result_addr;
		send_request(CMD_RESIZE, a1, 19'd40000);
		send_request(CMD_RESIZE, a1, 19'd262144);
		send_request(CMD_FREE, 16'hffff, 19'd0);
		send_request(CMD_FREE, big, 19'd0);
		send_request(CMD_RESIZE, 16'hffff, 19'd8);
		send_request(CMD_FREE, a1, 19'd0);

		// Back-pressure: hold the response side while requests keep coming.
		hold_cycles = 400;
		for (int i = 0; i < 30; i++)
			random_request();

		for (int ph = 0; ph < 4; ph++) begin
			send_gap_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 53 : 37) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 53 : 37) : 0;
			for (int i = 0; i < 180; i++) begin
				idle_sender();
				random_request();
			end
		end
		@(negedge clk);
		req.valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Checked %0d responses: %0d granted, %0d relocations, %0d no-space, %0d null.",
			sb.checked, sb.grants, sb.moves, sb.nospace, sb.nulls);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
